// File: src/tsl_pkg.sv
// Shared types and constants for the triangle strip to list converter.
// Used by the front, the triangle queue, the back and the top level.
package tsl_pkg;

  localparam int IDX_W     = 32;
  localparam int VTX_W     = IDX_W + 1;
  localparam int IN_DATA_W = ((VTX_W + 7) / 8) * 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // One triangle in the order its indices leave the block.
  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] third;
  } triangle_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: src/tsl_front.sv
// Front of the converter: accepts strip indices, keeps the held pair and
// parity, and pushes each non-degenerate triangle into the queue. Uses tsl_pkg.
module tsl_front
  import tsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VTX_W-1:0]     in_vertex,
  input  logic                 in_eos,
  input  queue_status_t        qstat,
  output logic                 push,
  output triangle_t            push_tri
);

  logic [IDX_W-1:0] older_index, older_index_next;
  logic [IDX_W-1:0] newer_index, newer_index_next;
  logic             older_valid, older_valid_next;
  logic             newer_valid, newer_valid_next;
  logic             odd_parity, odd_parity_next;

  logic             accept;
  logic             negative;
  logic [IDX_W-1:0] c;
  logic             distinct;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign negative = in_vertex[VTX_W-1];
  assign c        = in_vertex[IDX_W-1:0];
  assign distinct = (older_index != newer_index) && (newer_index != c) &&
                    (older_index != c);

  always_comb begin
    older_index_next = older_index;
    newer_index_next = newer_index;
    older_valid_next = older_valid;
    newer_valid_next = newer_valid;
    odd_parity_next  = odd_parity;
    push             = 1'b0;
    push_tri.first   = odd_parity ? newer_index : older_index;
    push_tri.second  = odd_parity ? older_index : newer_index;
    push_tri.third   = c;
    if (accept) begin
      if (negative) begin
        older_valid_next = 1'b0;
        newer_valid_next = 1'b0;
        odd_parity_next  = 1'b0;
      end else if (!older_valid) begin
        older_index_next = c;
        older_valid_next = 1'b1;
      end else if (!newer_valid) begin
        newer_index_next = c;
        newer_valid_next = 1'b1;
      end else begin
        push             = distinct;
        older_index_next = newer_index;
        newer_index_next = c;
        odd_parity_next  = !odd_parity;
      end
      // The end of a strip wipes whatever the item left behind.
      if (in_eos) begin
        older_valid_next = 1'b0;
        newer_valid_next = 1'b0;
        odd_parity_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_valid <= 1'b0;
      newer_valid <= 1'b0;
      odd_parity  <= 1'b0;
      older_index <= '0;
      newer_index <= '0;
    end else begin
      older_valid <= older_valid_next;
      newer_valid <= newer_valid_next;
      odd_parity  <= odd_parity_next;
      older_index <= older_index_next;
      newer_index <= newer_index_next;
    end
  end

endmodule

// File: src/tsl_queue.sv
// Short first-in first-out queue of triangles between the front and the back.
// Depth comes from tsl_pkg.
module tsl_queue
  import tsl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  triangle_t     push_tri,
  input  logic          pop,
  output triangle_t     pop_tri,
  output queue_status_t qstat
);

  triangle_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_tri     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// File: src/tsl_back.sv
// Back of the converter: takes triangles from the queue and sends their three
// indices out one item per cycle while out_ready is high. Uses tsl_pkg.
module tsl_back
  import tsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  queue_status_t    qstat,
  input  triangle_t        pop_tri,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_index,
  output logic             out_last
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  triangle_t  cur;
  logic       busy;
  logic [1:0] phase;
  logic       sent;

  assign out_valid = busy;
  assign sent      = busy && out_ready;
  // Load the next triangle as soon as the last index of this one goes out.
  assign pop       = !qstat.empty && (!busy || (sent && phase == PH_THIRD));
  assign out_last  = (phase == PH_THIRD);

  always_comb begin
    case (phase)
      PH_FIRST:  out_index = cur.first;
      PH_SECOND: out_index = cur.second;
      default:   out_index = cur.third;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_FIRST;
    end else if (pop) begin
      busy  <= 1'b1;
      phase <= PH_FIRST;
    end else if (sent) begin
      case (phase)
        PH_FIRST:  phase <= PH_SECOND;
        PH_SECOND: phase <= PH_THIRD;
        default: begin
          phase <= PH_FIRST;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: src/triangle_strip_to_list.sv
// Triangle strip to triangle list converter, one strip index per input item
// and one list index per output item. Built from tsl_front, tsl_queue, tsl_back.
//
// An input item that only fills or clears the held pair, or forms a degenerate
// triangle, is taken whenever the triangle queue has room. An emitted triangle
// leaves as three output items in turn, so a strip of non-degenerate triangles
// is paced by the output serializer. A two-entry triangle queue separates the
// input side from the output side, so input keeps flowing while the output port
// is stalled until that queue fills; while it is full every input item waits,
// whatever it does. When the block is empty, a triangle reaches the output
// through the queue entry and then the triangle register of the back.
module triangle_strip_to_list
  import tsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // [32:0] signed strip index, rest zero
  input  logic                 s_axis_tlast,  // end_of_strip
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [IDX_W-1:0]     m_axis_tdata,  // [31:0] out_index
  output logic                 m_axis_tlast   // last_of_triangle
);

  queue_status_t qstat;
  logic          push;
  logic          pop;
  triangle_t     push_tri;
  triangle_t     pop_tri;

  tsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_vertex (s_axis_tdata[VTX_W-1:0]),
    .in_eos    (s_axis_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_tri  (push_tri)
  );

  tsl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tri (push_tri),
    .pop      (pop),
    .pop_tri  (pop_tri),
    .qstat    (qstat)
  );

  tsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_tri   (pop_tri),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for triangle_strip_to_list: drives strip indices on the
// input stream and checks every list index against a predictor of its own.
// Depends on tsl_pkg and the triangle_strip_to_list top level.
`timescale 1ns / 100ps

module tb_top;
  import tsl_pkg::*;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             eos;
  } strip_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } list_index_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;  // [32:0] signed strip index, rest zero
  logic                 s_axis_tlast = 1'b0;  // end_of_strip
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [IDX_W-1:0]     m_axis_tdata;  // [31:0] out_index
  logic                 m_axis_tlast;  // last_of_triangle

  strip_item_t pending_strip[$];
  list_index_t expected_list[$];
  strip_item_t next_item;
  logic        in_fire = 1'b0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          idle_phase;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Predictor state: the held pair of strip indices and the winding parity.
  logic [IDX_W-1:0] held_older;
  logic             held_older_ok;
  logic [IDX_W-1:0] held_newer;
  logic             held_newer_ok;
  logic             parity_odd;

  triangle_strip_to_list u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic clear_strip_state();
    held_older    = '0;
    held_older_ok = 1'b0;
    held_newer    = '0;
    held_newer_ok = 1'b0;
    parity_odd    = 1'b0;
  endtask

  task automatic expect_index(input logic [IDX_W-1:0] idx, input logic last);
    list_index_t e;
    e.idx  = idx;
    e.last = last;
    expected_list.insert(expected_list.size(), e);
  endtask

  task automatic convert_strip_index(input strip_item_t it);
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    a = held_older;
    b = held_newer;
    c = it.vertex[IDX_W-1:0];
    if (it.vertex[VTX_W-1]) begin
      clear_strip_state();
    end else if (!held_older_ok) begin
      held_older    = c;
      held_older_ok = 1'b1;
    end else if (!held_newer_ok) begin
      held_newer    = c;
      held_newer_ok = 1'b1;
    end else begin
      if (a != b && b != c && a != c) begin
        if (!parity_odd) begin
          expect_index(a, 1'b0);
          expect_index(b, 1'b0);
        end else begin
          expect_index(b, 1'b0);
          expect_index(a, 1'b0);
        end
        expect_index(c, 1'b1);
      end
      held_older = b;
      held_newer = c;
      parity_odd = !parity_odd;
    end
    if (it.eos) clear_strip_state();
  endtask

  task automatic add_item(input logic [VTX_W-1:0] vertex, input logic eos);
    strip_item_t s;
    s.vertex = vertex;
    s.eos    = eos;
    pending_strip.insert(pending_strip.size(), s);
  endtask

  function automatic logic [VTX_W-1:0] restart_vertex();
    logic [31:0] mag;
    mag = $urandom_range(32'h8000_0000, 1);
    return {VTX_W{1'b0}} - {1'b0, mag};
  endfunction

  // Driver: a new item goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      idle_phase = (cycle_count / 600) % 4;
      case (idle_phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (!s_axis_tvalid || in_fire) begin
        if (pending_strip.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_strip.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_DATA_W-VTX_W){1'b0}}, next_item.vertex};
          s_axis_tlast  <= next_item.eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: outputs are checked before the input of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_list.size() == 0) begin
          $error("out_index: unexpected item, actual %h", m_axis_tdata);
          error_count++;
        end else begin
          if (m_axis_tdata !== expected_list[0].idx) begin
            $error("out_index: expected %h, actual %h", expected_list[0].idx, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== expected_list[0].last) begin
            $error("last_of_triangle: expected %b, actual %b",
                   expected_list[0].last, m_axis_tlast);
            error_count++;
          end
          void'(expected_list.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        convert_strip_index('{vertex: s_axis_tdata[VTX_W-1:0], eos: s_axis_tlast});
    end
  end

  initial begin
    int               generated;
    int               strip_len;
    int               value_mode;
    int               roll;
    logic [VTX_W-1:0] v;
    logic             eos;

    clear_strip_state();

    // Directed strip: winding order, each kind of degenerate triangle, extremes.
    add_item(33'd10, 1'b0);
    add_item(33'd20, 1'b0);
    add_item(33'd30, 1'b0);
    add_item(33'd40, 1'b0);
    add_item(33'd40, 1'b0);          // newer equals new index
    add_item(33'd50, 1'b0);          // held pair equal
    add_item(33'd40, 1'b0);          // older equals new index
    add_item(33'h0_FFFF_FFFF, 1'b0);
    add_item(33'd0, 1'b1);           // triangle plus end of strip
    add_item(33'h1_FFFF_FFFF, 1'b0); // restart with nothing held
    add_item(33'd5, 1'b0);
    add_item(33'd6, 1'b0);
    add_item(33'h1_8000_0000, 1'b0); // restart of -2^31 with a full pair
    add_item(33'd1, 1'b0);
    add_item(33'd2, 1'b0);
    add_item(33'd3, 1'b1);
    add_item(33'h1_FFFF_FFFF, 1'b1); // restart that also ends the strip
    add_item(33'd7, 1'b0);
    add_item(33'd8, 1'b1);           // strip that never gets past filling
    add_item(33'd0, 1'b0);
    add_item(33'h0_FFFF_FFFF, 1'b0);
    add_item(33'h0_8000_0000, 1'b0);
    add_item(33'h0_7FFF_FFFF, 1'b1);

    // Random strips; small index pools make degenerate triangles common.
    generated = 0;
    while (generated < 500) begin
      value_mode = $urandom_range(2);
      strip_len  = $urandom_range(12, 1);
      for (int i = 0; i < strip_len; i++) begin
        roll = $urandom_range(99);
        if (roll < 4)
          v = restart_vertex();
        else if (value_mode == 0)
          v = 33'($urandom_range(5));
        else if (value_mode == 1)
          v = 33'($urandom_range(31));
        else
          v = {1'b0, 32'($urandom)};
        if (roll >= 95)
          eos = 1'($urandom_range(1));
        else
          eos = (i == strip_len - 1) && ($urandom_range(9) != 0);
        add_item(v, eos);
        generated++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_strip.size() != 0 || s_axis_tvalid);
    while (expected_list.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_list.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
